### design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types and constants for the first-fit pool allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int unsigned MaxAllocsDef   = 16;
	localparam int unsigned HeaderBytesDef = 24;
	localparam logic [15:0] PoolReset      = 16'd4096;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_STATS = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] request_bytes;
		logic [15:0] release_offset;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] data_offset;
		logic [15:0] bytes_allocated;
		logic [15:0] bytes_free;
		logic [15:0] largest_gap;
		logic [4:0]  gap_count;
		logic [4:0]  live_count;
	} out_word_t;

	// one table entry: data offset and data size
	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] bytes;
	} entry_t;

endpackage

### design/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// generic ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module ffpa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### design/first_fit_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// alloc scans for a fit and shifts up, free scans and shifts down, stats scans all
// one word at a time, taken only after the last result has been accepted
// reset: async; clears count and control, pool size back to 4096, table left undefined
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core #(
	parameter int unsigned MAX_ALLOCS   = ffpa_pkg::MaxAllocsDef,
	parameter int unsigned HEADER_BYTES = ffpa_pkg::HeaderBytesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  ffpa_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ffpa_pkg::out_word_t out_data
);
	import ffpa_pkg::*;

	localparam int unsigned AW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
	localparam int unsigned CW = $clog2(MAX_ALLOCS + 1);
	localparam logic [16:0] HDR = 17'(HEADER_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_SCAN, S_FIT, S_INS_RD, S_INS_WR, S_INS_PUT,
		S_DEL_RD, S_DEL_WR, S_DONE, S_OUT
	} state_t;

	state_t      state_q;
	logic [15:0] pool_q;
	logic [CW-1:0] count_q, idx_q, pos_q;
	in_word_t    req_q;
	logic [16:0] free_q;       // end of previous allocation
	logic [16:0] largest_q;
	logic [4:0]  gaps_q;
	logic [16:0] total_q;
	out_word_t   res_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	ffpa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ALLOCS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// shared gap unit: gap from free_q to a bound
	logic [16:0] bound, gap, hstart, need;
	assign hstart = ({1'b0, rdata.offset} >= HDR) ? {1'b0, rdata.offset} - HDR : 17'd0;
	assign need   = {1'b0, req_q.request_bytes} + HDR;
	always_comb begin
		bound = (idx_q == count_q) ? {1'b0, pool_q} : hstart;
		gap   = (bound > free_q) ? bound - free_q : 17'd0;
	end

	logic [16:0] new_off;
	assign new_off = free_q + HDR;

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_INS_RD: raddr = AW'(idx_q - 1'b1);
			S_INS_WR: we = 1'b1;
			S_INS_PUT: begin
				we    = 1'b1;
				wdata = '{offset: new_off[15:0], bytes: req_q.request_bytes};
			end
			S_DEL_RD: raddr = AW'(idx_q + 1'b1);
			S_DEL_WR: we = 1'b1;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pool_q  <= PoolReset;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					req_q     <= in_data;
					idx_q     <= '0;
					free_q    <= '0;
					largest_q <= '0;
					gaps_q    <= '0;
					total_q   <= '0;
					res_q     <= '0;
					priority case (op_t'(in_data.operation))
						OP_ALLOC: begin
							if (in_data.request_bytes == '0 || count_q >= CW'(MAX_ALLOCS)) begin
								res_q.status <= ST_NOFIT;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_RD;
							end
						end
						OP_FREE, OP_STATS: state_q <= S_RD;
						default: state_q <= S_OUT;
					endcase
				end
				S_RD: state_q <= S_SCAN; // read data arrives next cycle
				S_SCAN: begin
					priority case (op_t'(req_q.operation))
						OP_ALLOC: begin
							if (gap >= need) begin
								pos_q   <= idx_q;
								state_q <= S_FIT;
							end else if (idx_q == count_q) begin
								res_q.status <= ST_NOFIT;
								state_q      <= S_OUT;
							end else begin
								free_q  <= {1'b0, rdata.offset} + {1'b0, rdata.bytes};
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
						OP_FREE: begin
							if (idx_q == count_q) begin
								res_q.status <= ST_UNKNOWN;
								state_q      <= S_OUT;
							end else if (rdata.offset == req_q.release_offset) begin
								state_q <= S_DEL_RD;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
						default: begin
							if (gap != '0) begin
								gaps_q <= gaps_q + 1'b1;
								if (gap > largest_q) largest_q <= gap;
							end
							if (idx_q == count_q) begin
								state_q <= S_DONE;
							end else begin
								total_q <= total_q + {1'b0, rdata.bytes};
								free_q  <= {1'b0, rdata.offset} + {1'b0, rdata.bytes};
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_FIT: begin
					// shift entries up from the top down to pos
					idx_q   <= count_q;
					state_q <= (count_q == pos_q) ? S_INS_PUT : S_INS_RD;
				end
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= ((idx_q - 1'b1) == pos_q) ? S_INS_PUT : S_INS_RD;
				end
				S_INS_PUT: begin
					count_q           <= count_q + 1'b1;
					res_q.data_offset <= new_off[15:0];
					state_q           <= S_OUT;
				end
				S_DEL_RD: begin
					if (idx_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_DEL_RD;
				end
				S_DONE: begin
					res_q.bytes_allocated <= (total_q > 17'hFFFF) ? 16'hFFFF : total_q[15:0];
					res_q.bytes_free      <= (pool_q > total_q[15:0] && total_q <= 17'hFFFF)
					                         ? pool_q - total_q[15:0] : 16'd0;
					res_q.largest_gap     <= largest_q[15:0];
					res_q.gap_count       <= gaps_q;
					res_q.live_count      <= 5'(count_q);
					state_q               <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/ffpa_checker.sv
// ----------------------------------------------------------------------------
// ffpa_checker
// port-level checks for the pool allocator
// ----------------------------------------------------------------------------
module ffpa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input ffpa_pkg::out_word_t out_data
);
	import ffpa_pkg::*;

	// one word at a time: no intake while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");

	// busy right after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after intake");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != ST_RSVD) else $error("bad status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.data_offset == '0)
		else $error("offset on failure");
endmodule

bind first_fit_pool_allocator_core ffpa_checker u_ffpa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
